FILE: src/soa_pkg.sv
// Shared types and constants for the slab object allocator.
package soa_pkg;

   localparam int LINK_W   = 10;
   localparam int OBJS_W   = 10;
   localparam int LIMIT_W  = 4;
   localparam int SLAB_W   = 3;
   localparam int OBJECT_W = 9;

   localparam logic       REQ_ALLOC = 1'b0;
   localparam logic       REQ_FREE  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOMEM = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_BAD   = 2'd2;

   localparam logic CSR_OBJS  = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0]          op;
      logic [SLAB_W-1:0]   slab;
      logic [OBJECT_W-1:0] obj;
   } soa_item_type;

endpackage

FILE: src/soa_front.sv
// Request intake: classifies each word and queues it for the execution unit.
module soa_front import soa_pkg::*; #(
   parameter int SLABS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [SLAB_W-1:0]   req_slab_id,
   input  logic [OBJECT_W-1:0] req_object_id,
   input  logic [OBJS_W-1:0]   n_eff,
   output logic                q_valid,
   output soa_item_type        q_item,
   input  logic                q_pop
);

   soa_item_type entry_ff [2];
   soa_item_type new_item;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;
   logic         do_pop;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];
   assign do_pop    = q_pop && q_valid;

   always_comb begin
      new_item.slab = req_slab_id;
      new_item.obj  = req_object_id;
      if (req_type == REQ_ALLOC) begin
         new_item.op = OP_ALLOC;
      end else if ((32'(req_slab_id) >= SLABS) || (OBJS_W'(req_object_id) >= n_eff)) begin
         new_item.op = OP_BAD;
      end else begin
         new_item.op = OP_FREE;
      end
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: src/soa_back.sv
// Execution unit: slab metadata, partial list, free-chain memory and result register.
module soa_back import soa_pkg::*; #(
   parameter int SLABS = 8,
   parameter int OBJS  = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  soa_item_type        q_item,
   output logic                q_pop,
   input  logic [OBJS_W-1:0]   n_eff,
   input  logic [LIMIT_W-1:0]  slab_limit,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [SLAB_W-1:0]   rsp_got_slab,
   output logic [OBJECT_W-1:0] rsp_got_object,
   output logic                rsp_slab_released,
   output logic                rsp_slab_became_full
);

   localparam int SW = (SLABS > 1) ? $clog2(SLABS) : 1;
   localparam int PW = $clog2(SLABS + 1);
   localparam int IW = (OBJS >= 1024) ? 10 : $clog2(OBJS);
   localparam int AW = SW + IW;
   localparam logic [PW-1:0] NIL = PW'(SLABS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_INIT = 2'd1;
   localparam logic [1:0] S_RD   = 2'd2;
   localparam logic [1:0] S_WB   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [SW-1:0]     cur_ff, cur_in;
   logic [IW-1:0]     cnt_ff, cnt_in;

   logic [LINK_W-1:0] head_ff  [SLABS];
   logic [LINK_W-1:0] head_in  [SLABS];
   logic [LINK_W-1:0] count_ff [SLABS];
   logic [LINK_W-1:0] count_in [SLABS];
   logic [PW-1:0]     next_ff  [SLABS];
   logic [PW-1:0]     next_in  [SLABS];
   logic [PW-1:0]     prev_ff  [SLABS];
   logic [PW-1:0]     prev_in  [SLABS];
   logic [SLABS-1:0]  taken_ff, taken_in;
   logic [SLABS-1:0]  on_ff, on_in;
   logic [PW-1:0]     phead_ff, phead_in;

   logic [LINK_W-1:0] mem [2**AW];
   logic [LINK_W-1:0] rd_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [LINK_W-1:0] mem_wd;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;

   logic                rsp_valid_ff;
   logic [1:0]          status_ff, status_in;
   logic [SLAB_W-1:0]   gslab_ff, gslab_in;
   logic [OBJECT_W-1:0] gobj_ff, gobj_in;
   logic                rel_ff, rel_in;
   logic                full_ff, full_in;
   logic                out_load;
   logic                out_free;

   logic          found;
   logic [SW-1:0] free_slot;
   logic [SW-1:0] s;
   logic [PW-1:0] lp, ln;
   logic [LINK_W-1:0] h, c, cur_head;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cur_head  = head_ff[cur_ff];
   assign rd_addr   = {cur_ff, (32'(cur_head) < OBJS) ? IW'(cur_head) : IW'(0)};

   always_comb begin
      found     = 1'b0;
      free_slot = '0;
      for (int i = SLABS - 1; i >= 0; i--) begin
         if (!taken_ff[i] && (i < 32'(slab_limit))) begin
            found     = 1'b1;
            free_slot = SW'(i);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      next_in   = next_ff;
      prev_in   = prev_ff;
      taken_in  = taken_ff;
      on_in     = on_ff;
      phead_in  = phead_ff;
      mem_we    = 1'b0;
      mem_wa    = '0;
      mem_wd    = '0;
      rd_en     = 1'b0;
      q_pop     = 1'b0;
      out_load  = 1'b0;
      status_in = ST_OK;
      gslab_in  = '0;
      gobj_in   = '0;
      rel_in    = 1'b0;
      full_in   = 1'b0;
      s         = SW'(q_item.slab);
      lp        = prev_ff[s];
      ln        = next_ff[s];
      h         = '0;
      c         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_item.op)
                  OP_ALLOC: begin
                     if (n_eff == '0) begin
                        out_load  = 1'b1;
                        status_in = ST_NOMEM;
                     end else if (phead_ff != NIL) begin
                        cur_in   = SW'(phead_ff);
                        state_in = S_RD;
                     end else if (found) begin
                        cur_in              = free_slot;
                        cnt_in              = '0;
                        taken_in[free_slot] = 1'b1;
                        count_in[free_slot] = '0;
                        head_in[free_slot]  = '0;
                        prev_in[free_slot]  = NIL;
                        next_in[free_slot]  = NIL;
                        on_in[free_slot]    = 1'b1;
                        phead_in            = PW'(free_slot);
                        state_in            = S_INIT;
                     end else begin
                        out_load  = 1'b1;
                        status_in = ST_NOMEM;
                     end
                  end
                  OP_FREE: begin
                     out_load = 1'b1;
                     if (!taken_ff[s]) begin
                        status_in = ST_BAD;
                     end else begin
                        mem_we     = 1'b1;
                        mem_wa     = {s, IW'(q_item.obj)};
                        mem_wd     = head_ff[s];
                        head_in[s] = LINK_W'(q_item.obj);
                        c          = count_ff[s] - 1'b1;
                        count_in[s] = c;
                        if (c == '0) begin
                           rel_in      = 1'b1;
                           taken_in[s] = 1'b0;
                           if (on_ff[s]) begin
                              if (lp != NIL) next_in[SW'(lp)] = ln;
                              else           phead_in         = ln;
                              if (ln != NIL) prev_in[SW'(ln)] = lp;
                              next_in[s] = NIL;
                              prev_in[s] = NIL;
                              on_in[s]   = 1'b0;
                           end
                        end else if (!on_ff[s]) begin
                           prev_in[s] = NIL;
                           next_in[s] = phead_ff;
                           if (phead_ff != NIL) prev_in[SW'(phead_ff)] = PW'(s);
                           phead_in = PW'(s);
                           on_in[s] = 1'b1;
                        end
                     end
                  end
                  default: begin
                     out_load  = 1'b1;
                     status_in = ST_BAD;
                  end
               endcase
            end
         end
         S_INIT: begin
            mem_we = 1'b1;
            mem_wa = {cur_ff, cnt_ff};
            mem_wd = LINK_W'(cnt_ff) + 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (LINK_W'(cnt_ff) + 1'b1 == n_eff) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            state_in = S_WB;
         end
         default: begin
            h                = head_ff[cur_ff];
            c                = count_ff[cur_ff] + 1'b1;
            head_in[cur_ff]  = rd_ff;
            count_in[cur_ff] = c;
            lp               = prev_ff[cur_ff];
            ln               = next_ff[cur_ff];
            out_load         = 1'b1;
            gslab_in         = SLAB_W'(cur_ff);
            gobj_in          = h[OBJECT_W-1:0];
            if (c >= n_eff) begin
               full_in = 1'b1;
               if (on_ff[cur_ff]) begin
                  if (lp != NIL) next_in[SW'(lp)] = ln;
                  else           phead_in         = ln;
                  if (ln != NIL) prev_in[SW'(ln)] = lp;
                  next_in[cur_ff] = NIL;
                  prev_in[cur_ff] = NIL;
                  on_in[cur_ff]   = 1'b0;
               end
            end
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         taken_ff     <= '0;
         on_ff        <= '0;
         phead_ff     <= NIL;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLABS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         taken_ff <= taken_in;
         on_ff    <= on_in;
         phead_ff <= phead_in;
         count_ff <= count_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      cnt_ff  <= cnt_in;
      head_ff <= head_in;
      next_ff <= next_in;
      prev_ff <= prev_in;
      if (out_load) begin
         status_ff <= status_in;
         gslab_ff  <= gslab_in;
         gobj_ff   <= gobj_in;
         rel_ff    <= rel_in;
         full_ff   <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_got_slab         = gslab_ff;
   assign rsp_got_object       = gobj_ff;
   assign rsp_slab_released    = rel_ff;
   assign rsp_slab_became_full = full_ff;

endmodule

FILE: src/slab_object_allocator.sv
// Top level of the slab object allocator: register file, intake queue and execution unit.
// Each word yields one response. A free, or any rejected word, is answered straight from
// the issue state of the execution unit; an allocate from a partial slab passes through issue,
// chain memory read and write-back. An allocate that claims a fresh slab first links its
// free chain through the single chain memory write port, one link per object. A two-entry
// intake queue and the response register let new words enter while a response waits.
module slab_object_allocator import soa_pkg::*; #(
   parameter int SLABS = 8,
   parameter int OBJS  = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [SLAB_W-1:0]   req_slab_id,
   input  logic [OBJECT_W-1:0] req_object_id,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [SLAB_W-1:0]   rsp_got_slab,
   output logic [OBJECT_W-1:0] rsp_got_object,
   output logic                rsp_slab_released,
   output logic                rsp_slab_became_full,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [OBJS_W-1:0]   csr_wdata
);

   logic [OBJS_W-1:0]  objs_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [OBJS_W-1:0]  n_eff;
   logic               q_valid;
   logic               q_pop;
   soa_item_type       q_item;

   assign csr_ready = 1'b1;
   assign n_eff     = (32'(objs_ff) > OBJS) ? OBJS_W'(OBJS) : objs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         objs_ff  <= OBJS_W'(512);
         limit_ff <= LIMIT_W'(8);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OBJS:  objs_ff  <= csr_wdata;
            default:   limit_ff <= csr_wdata[LIMIT_W-1:0];
         endcase
      end
   end

   soa_front #(.SLABS(SLABS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_slab_id   (req_slab_id),
      .req_object_id (req_object_id),
      .n_eff         (n_eff),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   soa_back #(.SLABS(SLABS), .OBJS(OBJS)) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_item               (q_item),
      .q_pop                (q_pop),
      .n_eff                (n_eff),
      .slab_limit           (limit_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_got_slab         (rsp_got_slab),
      .rsp_got_object       (rsp_got_object),
      .rsp_slab_released    (rsp_slab_released),
      .rsp_slab_became_full (rsp_slab_became_full)
   );

endmodule

FILE: src/soa_checker.sv
// Port-level checks for the slab object allocator, bound to the top level.
module soa_checker import soa_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_status,
   input logic [SLAB_W-1:0]   rsp_got_slab,
   input logic [OBJECT_W-1:0] rsp_got_object,
   input logic                rsp_slab_released,
   input logic                rsp_slab_became_full
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_got_slab)
         && $stable(rsp_got_object))
      else $error("stalled response changed");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_NOMEM || rsp_status == ST_BAD)
      else $error("bad status code");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_got_slab == '0 && rsp_got_object == '0
         && !rsp_slab_released && !rsp_slab_became_full)
      else $error("error response carries data");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slab_released |-> !rsp_slab_became_full && rsp_got_slab == '0)
      else $error("release flag on an allocate");

endmodule

bind slab_object_allocator soa_checker u_soa_checker (.*);
